>>> rtl/astol_pkg.sv
// Shared types and constants of the grid-indexed A* open-list table.
package astol_pkg;

   localparam int COORD_W = 4;
   localparam int ORDER_W = 8;
   localparam int G_W     = 10;
   localparam int H_W     = 5;
   localparam int F_W     = 11;
   localparam int COUNT_W = 9;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W = 4;

   localparam logic [COUNT_W-1:0] MAX_ENTRIES = 9'd256;
   localparam logic [G_W-1:0]     G_MAX       = 10'd1023;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd3;
   localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_REJECT   = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_X = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_Y = 4'd1;

   // One open-list entry as it travels around the ring.
   typedef struct packed {
      logic               valid;
      logic [ORDER_W-1:0] order;
      logic [G_W-1:0]     g;
      logic [H_W-1:0]     h;
      logic [F_W-1:0]     f;
      logic [COORD_W-1:0] parent_y;
      logic [COORD_W-1:0] parent_x;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

endpackage

>>> rtl/astol_req_if.sv
// Request channel: one operation word.
interface astol_req_if;
   logic                              valid;
   logic                              ready;
   logic [astol_pkg::OP_W-1:0]        opcode;
   logic [astol_pkg::COORD_W-1:0]     cell_x;
   logic [astol_pkg::COORD_W-1:0]     cell_y;
   logic [astol_pkg::COORD_W-1:0]     parent_x;
   logic [astol_pkg::COORD_W-1:0]     parent_y;
   logic [astol_pkg::G_W-1:0]         parent_g;
   logic [astol_pkg::ORDER_W-1:0]     order_index;

   modport source (output valid, opcode, cell_x, cell_y, parent_x, parent_y, parent_g,
                   order_index, input ready);
   modport sink (input valid, opcode, cell_x, cell_y, parent_x, parent_y, parent_g,
                 order_index, output ready);
endinterface

>>> rtl/astol_rsp_if.sv
// Response channel: one result word per operation.
interface astol_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [astol_pkg::STAT_W-1:0]  status;
   logic [astol_pkg::COORD_W-1:0] out_x;
   logic [astol_pkg::COORD_W-1:0] out_y;
   logic [astol_pkg::G_W-1:0]     out_g;
   logic [astol_pkg::H_W-1:0]     out_h;
   logic [astol_pkg::F_W-1:0]     out_f;
   logic [astol_pkg::ORDER_W-1:0] out_order;
   logic [astol_pkg::COORD_W-1:0] out_parent_x;
   logic [astol_pkg::COORD_W-1:0] out_parent_y;
   logic [astol_pkg::COUNT_W-1:0] count;

   modport source (output valid, status, out_x, out_y, out_g, out_h, out_f, out_order,
                   out_parent_x, out_parent_y, count, input ready);
   modport sink (input valid, status, out_x, out_y, out_g, out_h, out_f, out_order,
                 out_parent_x, out_parent_y, count, output ready);
endinterface

>>> rtl/astol_csr_if.sv
// Configuration write channel.
interface astol_csr_if;
   logic                            valid;
   logic                            ready;
   logic [astol_pkg::CSR_IDX_W-1:0] index;
   logic [astol_pkg::COORD_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/astar_open_list_table.sv
// Top level of the grid-indexed A* open-list table.
// The block keeps one entry per grid cell in a ring of cells that rotates
// by one place per clock while an operation scans the ring. The sequencer reads and
// rewrites the entry at the head of the ring.
// Channels: req takes one operation word (clear, insert, remove, lookup,
// reverse); rsp returns exactly one result word per operation; csr writes
// the goal column (index 0) and goal row (index 1) and is always ready.
// Clear, insert, lookup and reverse take one full ring rotation; a remove
// that hits takes two. Out-of-grid inserts and removes and unknown codes
// answer without a rotation. One operation is in flight at a time and req
// is ready again in the cycle after the result loads.
// Reset empties the table and sets the goal to cell zero.
// A stalled receiver holds the result in the output register; the next
// operation may run meanwhile and its result waits until the register frees.
module astar_open_list_table #(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 16
) (
   input logic         clock,
   input logic         reset,
   astol_req_if.sink   req,
   astol_rsp_if.source rsp,
   astol_csr_if.sink   csr
);

   localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

   astol_pkg::entry_type ring_q [CELLS];
   astol_pkg::entry_type tail_d;
   logic                 shift;

   astol_ctrl #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .rsp    (rsp),
      .csr    (csr),
      .head_q (ring_q[0]),
      .tail_d (tail_d),
      .shift  (shift)
   );

   // Each cell takes its neighbor's entry; the last takes the processed head.
   for (genvar i = 0; i < CELLS; i++) begin : g_ring
      if (i == CELLS - 1) begin : g_tail
         astol_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d     (tail_d),
            .q     (ring_q[i])
         );
      end else begin : g_body
         astol_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (shift),
            .d     (ring_q[i+1]),
            .q     (ring_q[i])
         );
      end
   end

endmodule

>>> rtl/astol_cell.sv
// One storage cell of the entry ring.
module astol_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  astol_pkg::entry_type d,
   output astol_pkg::entry_type q
);

   logic                 valid_ff;
   astol_pkg::entry_type data_ff;

   // The valid mark is control state and clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   // Payload moves with the ring and needs no reset.
   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= d;
      end
   end

   always_comb begin
      q       = data_ff;
      q.valid = valid_ff;
   end

endmodule

>>> rtl/astol_ctrl.sv
// Sequencer and head-of-ring processing for the open-list table.
module astol_ctrl #(
   parameter int GRID_WIDTH  = 16,
   parameter int GRID_HEIGHT = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   astol_req_if.sink            req,
   astol_rsp_if.source          rsp,
   astol_csr_if.sink            csr,
   input  astol_pkg::entry_type head_q,
   output astol_pkg::entry_type tail_d,
   output logic                 shift
);

   localparam int XW = $clog2(GRID_WIDTH);
   localparam int YW = $clog2(GRID_HEIGHT);

   astol_pkg::state_type state_ff, state_in;

   logic [astol_pkg::OP_W-1:0]    op_ff;
   logic [astol_pkg::COORD_W-1:0] cx_ff, cy_ff, px_ff, py_ff;
   logic [astol_pkg::G_W-1:0]     pg_ff;
   logic [astol_pkg::ORDER_W-1:0] want_ff;
   logic [astol_pkg::COORD_W-1:0] goal_x_ff, goal_y_ff;
   logic [XW-1:0]                 x_ff;
   logic [YW-1:0]                 y_ff;
   logic                          pass_ff;
   logic                          found_ff;
   logic [astol_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [astol_pkg::ORDER_W-1:0] gone_ff;
   logic [astol_pkg::STAT_W-1:0]  res_status_ff, cap_status;
   astol_pkg::entry_type          res_entry_ff, cap_entry;
   logic [astol_pkg::COORD_W-1:0] res_x_ff, res_y_ff;
   logic                          rsp_valid_ff;
   astol_pkg::entry_type          rsp_entry_ff;
   logic [astol_pkg::STAT_W-1:0]  rsp_status_ff;
   logic [astol_pkg::COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [astol_pkg::COUNT_W-1:0] rsp_count_ff;

   logic req_fire, in_grid, quick, at_cell, last, cap_en, load_rsp, next_pass;
   logic [astol_pkg::G_W-1:0]     new_g;
   logic [astol_pkg::H_W-1:0]     new_h;
   logic [astol_pkg::COORD_W-1:0] dx, dy;

   assign req_fire = req.valid && req.ready;
   assign in_grid  = (32'(req.cell_x) < GRID_WIDTH) && (32'(req.cell_y) < GRID_HEIGHT);
   // Out-of-grid inserts and removes and unknown codes answer without a pass.
   assign quick = (req.opcode > astol_pkg::OP_REVERSE)
                  || (((req.opcode == astol_pkg::OP_INSERT)
                      || (req.opcode == astol_pkg::OP_REMOVE)) && !in_grid);
   assign at_cell = (7'(x_ff) == 7'(cx_ff)) && (7'(y_ff) == 7'(cy_ff));
   assign last    = (x_ff == XW'(GRID_WIDTH - 1)) && (y_ff == YW'(GRID_HEIGHT - 1));
   // A remove that hits needs a second pass, even when the hit is the last cell.
   assign next_pass = (op_ff == astol_pkg::OP_REMOVE) && !pass_ff && (found_ff || cap_en);

   // Costs of a new entry.
   assign new_g = (pg_ff == astol_pkg::G_MAX) ? astol_pkg::G_MAX : pg_ff + 1'b1;
   assign dx    = (goal_x_ff > cx_ff) ? goal_x_ff - cx_ff : cx_ff - goal_x_ff;
   assign dy    = (goal_y_ff > cy_ff) ? goal_y_ff - cy_ff : cy_ff - goal_y_ff;
   assign new_h = 5'(dx) + 5'(dy);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         astol_pkg::S_IDLE: begin
            if (req_fire) state_in = quick ? astol_pkg::S_FLUSH : astol_pkg::S_SCAN;
         end
         astol_pkg::S_SCAN: begin
            if (last && !next_pass) state_in = astol_pkg::S_FLUSH;
         end
         astol_pkg::S_FLUSH: begin
            if (!rsp_valid_ff || rsp.ready) state_in = astol_pkg::S_IDLE;
         end
         default: state_in = astol_pkg::S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req.ready = 1'b0;
      shift     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         astol_pkg::S_IDLE:  req.ready = 1'b1;
         astol_pkg::S_SCAN:  shift = 1'b1;
         astol_pkg::S_FLUSH: load_rsp = !rsp_valid_ff || rsp.ready;
         default: ;
      endcase
   end

   // Work on the entry passing the head of the ring.
   always_comb begin
      tail_d     = head_q;
      cap_en     = 1'b0;
      cap_entry  = head_q;
      cap_status = astol_pkg::ST_DONE;
      count_in   = count_ff;
      case (op_ff)
         astol_pkg::OP_CLEAR: tail_d.valid = 1'b0;
         astol_pkg::OP_INSERT: begin
            if (at_cell) begin
               cap_en = 1'b1;
               if (head_q.valid) begin
                  cap_status = astol_pkg::ST_REJECT;
               end else if (count_ff >= astol_pkg::MAX_ENTRIES) begin
                  cap_status = astol_pkg::ST_REJECT;
                  cap_entry  = '0;
               end else begin
                  tail_d.valid    = 1'b1;
                  tail_d.order    = count_ff[astol_pkg::ORDER_W-1:0];
                  tail_d.g        = new_g;
                  tail_d.h        = new_h;
                  tail_d.f        = 11'(new_g) + 11'(new_h);
                  tail_d.parent_x = px_ff;
                  tail_d.parent_y = py_ff;
                  cap_entry       = tail_d;
                  count_in        = count_ff + 1'b1;
               end
            end
         end
         astol_pkg::OP_REMOVE: begin
            if (!pass_ff) begin
               cap_en = at_cell && head_q.valid;
            end else begin
               if (head_q.valid && head_q.order > gone_ff) tail_d.order = head_q.order - 1'b1;
               if (at_cell) tail_d.valid = 1'b0;
            end
         end
         astol_pkg::OP_LOOKUP: begin
            cap_en = head_q.valid && (head_q.order == want_ff) && !found_ff;
         end
         astol_pkg::OP_REVERSE: begin
            if (head_q.valid && (9'(head_q.order) < count_ff)) begin
               tail_d.order = 8'(count_ff - 9'd1 - 9'(head_q.order));
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= astol_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready) begin
            if (csr.index == astol_pkg::REG_GOAL_X) goal_x_ff <= csr.data;
            if (csr.index == astol_pkg::REG_GOAL_Y) goal_y_ff <= csr.data;
         end
         if (req_fire && req.opcode == astol_pkg::OP_CLEAR) begin
            count_ff <= '0;
         end else if (shift) begin
            if (last && op_ff == astol_pkg::OP_REMOVE && pass_ff) count_ff <= count_ff - 1'b1;
            else count_ff <= count_in;
         end
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Request word, scan position and gathered result.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req.opcode;
         cx_ff    <= req.cell_x;
         cy_ff    <= req.cell_y;
         px_ff    <= req.parent_x;
         py_ff    <= req.parent_y;
         pg_ff    <= req.parent_g;
         want_ff  <= req.order_index;
         x_ff     <= '0;
         y_ff     <= '0;
         pass_ff  <= 1'b0;
         found_ff <= 1'b0;
         res_entry_ff <= '0;
         res_x_ff <= '0;
         res_y_ff <= '0;
         res_status_ff <= (req.opcode == astol_pkg::OP_CLEAR
                           || req.opcode == astol_pkg::OP_REVERSE)
                          ? astol_pkg::ST_DONE : astol_pkg::ST_NOTFOUND;
      end else if (shift) begin
         if (x_ff == XW'(GRID_WIDTH - 1)) begin
            x_ff <= '0;
            y_ff <= last ? '0 : y_ff + 1'b1;
         end else begin
            x_ff <= x_ff + 1'b1;
         end
         if (last) pass_ff <= 1'b1;
         if (cap_en) begin
            found_ff      <= 1'b1;
            gone_ff       <= head_q.order;
            res_entry_ff  <= cap_entry;
            res_status_ff <= cap_status;
            res_x_ff      <= 4'(x_ff);
            res_y_ff      <= 4'(y_ff);
            if (cap_status == astol_pkg::ST_REJECT && !head_q.valid) begin
               res_x_ff <= '0;
               res_y_ff <= '0;
            end
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_entry_ff  <= res_entry_ff;
         rsp_x_ff      <= res_x_ff;
         rsp_y_ff      <= res_y_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign csr.ready        = 1'b1;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.out_x        = rsp_x_ff;
   assign rsp.out_y        = rsp_y_ff;
   assign rsp.out_g        = rsp_entry_ff.g;
   assign rsp.out_h        = rsp_entry_ff.h;
   assign rsp.out_f        = rsp_entry_ff.f;
   assign rsp.out_order    = rsp_entry_ff.order;
   assign rsp.out_parent_x = rsp_entry_ff.parent_x;
   assign rsp.out_parent_y = rsp_entry_ff.parent_y;
   assign rsp.count        = rsp_count_ff;

endmodule

>>> rtl/astol_chk.sv
// Port checker for the open-list table and its bind.
module astol_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
      else $error("response word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an operation is in flight");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind astar_open_list_table astol_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.status),
   .rsp_count  (rsp.count)
);

>>> verif/tb_astar_open_list_table.sv
// Self-checking testbench for the grid-indexed A* open-list table.
module tb_astar_open_list_table;

   localparam int GRID_W  = 16;
   localparam int GRID_H  = 16;
   localparam int CELLS   = GRID_W * GRID_H;
   localparam int RAND_PHASE_ITEMS = 190;
   localparam int DRAIN_CYCLES     = 2 * CELLS + 40;

   typedef struct {
      logic [astol_pkg::OP_W-1:0]    opcode;
      logic [astol_pkg::COORD_W-1:0] cell_x;
      logic [astol_pkg::COORD_W-1:0] cell_y;
      logic [astol_pkg::COORD_W-1:0] parent_x;
      logic [astol_pkg::COORD_W-1:0] parent_y;
      logic [astol_pkg::G_W-1:0]     parent_g;
      logic [astol_pkg::ORDER_W-1:0] order_index;
   } op_word_type;

   typedef struct {
      logic [astol_pkg::STAT_W-1:0]  status;
      logic [astol_pkg::COORD_W-1:0] out_x;
      logic [astol_pkg::COORD_W-1:0] out_y;
      logic [astol_pkg::G_W-1:0]     out_g;
      logic [astol_pkg::H_W-1:0]     out_h;
      logic [astol_pkg::F_W-1:0]     out_f;
      logic [astol_pkg::ORDER_W-1:0] out_order;
      logic [astol_pkg::COORD_W-1:0] out_parent_x;
      logic [astol_pkg::COORD_W-1:0] out_parent_y;
      logic [astol_pkg::COUNT_W-1:0] count;
   } result_word_type;

   logic clock;
   logic reset;

   astol_req_if req_ch ();
   astol_rsp_if rsp_ch ();
   astol_csr_if csr_ch ();

   astar_open_list_table #(
      .GRID_WIDTH  (GRID_W),
      .GRID_HEIGHT (GRID_H)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   // Shadow copy of the open-list table.
   logic                          tbl_valid [CELLS];
   logic [astol_pkg::ORDER_W-1:0] tbl_order [CELLS];
   logic [astol_pkg::G_W-1:0]     tbl_g [CELLS];
   logic [astol_pkg::H_W-1:0]     tbl_h [CELLS];
   logic [astol_pkg::F_W-1:0]     tbl_f [CELLS];
   logic [astol_pkg::COORD_W-1:0] tbl_px [CELLS];
   logic [astol_pkg::COORD_W-1:0] tbl_py [CELLS];
   logic [astol_pkg::COUNT_W-1:0] tbl_count;
   logic [astol_pkg::COORD_W-1:0] goal_col;
   logic [astol_pkg::COORD_W-1:0] goal_row;

   op_word_type     pending_ops[$];
   result_word_type awaited_results[$];
   op_word_type     cur_op;
   int              send_gap;
   int              stall_len;
   int              error_count;
   int              words_sent;
   int              words_checked;
   int              op_seen [8];
   int              status_seen [4];

   // Clock generation.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Inputs start at known values.
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.opcode      = '0;
      req_ch.cell_x      = '0;
      req_ch.cell_y      = '0;
      req_ch.parent_x    = '0;
      req_ch.parent_y    = '0;
      req_ch.parent_g    = '0;
      req_ch.order_index = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = astol_pkg::REG_GOAL_X;
      csr_ch.data        = '0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   function automatic result_word_type entry_word(logic [astol_pkg::STAT_W-1:0] st, int idx);
      result_word_type r;
      r = '{default: '0};
      r.status = st;
      if (idx >= 0) begin
         r.out_x        = 4'(idx % GRID_W);
         r.out_y        = 4'(idx / GRID_W);
         r.out_g        = tbl_g[idx];
         r.out_h        = tbl_h[idx];
         r.out_f        = tbl_f[idx];
         r.out_order    = tbl_order[idx];
         r.out_parent_x = tbl_px[idx];
         r.out_parent_y = tbl_py[idx];
      end
      return r;
   endfunction

   // Apply one operation to the shadow table and return its result word.
   function automatic result_word_type apply_table_op(op_word_type w);
      result_word_type               r;
      int                            idx;
      int                            gval;
      int                            hval;
      logic [astol_pkg::ORDER_W-1:0] gone;
      idx = int'(w.cell_y) * GRID_W + int'(w.cell_x);
      r   = entry_word(astol_pkg::ST_NOTFOUND, -1);
      case (w.opcode)
         astol_pkg::OP_CLEAR: begin
            foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            tbl_count = '0;
            r = entry_word(astol_pkg::ST_DONE, -1);
         end
         astol_pkg::OP_INSERT: begin
            if (tbl_valid[idx]) begin
               r = entry_word(astol_pkg::ST_REJECT, idx);
            end else if (tbl_count >= astol_pkg::MAX_ENTRIES) begin
               r = entry_word(astol_pkg::ST_REJECT, -1);
            end else begin
               gval = int'(w.parent_g) + 1;
               if (gval > int'(astol_pkg::G_MAX)) gval = int'(astol_pkg::G_MAX);
               hval = int'(goal_col > w.cell_x ? goal_col - w.cell_x : w.cell_x - goal_col)
                    + int'(goal_row > w.cell_y ? goal_row - w.cell_y : w.cell_y - goal_row);
               tbl_valid[idx] = 1'b1;
               tbl_order[idx] = tbl_count[astol_pkg::ORDER_W-1:0];
               tbl_g[idx]     = 10'(gval);
               tbl_h[idx]     = 5'(hval);
               tbl_f[idx]     = 11'(gval + hval);
               tbl_px[idx]    = w.parent_x;
               tbl_py[idx]    = w.parent_y;
               tbl_count      = tbl_count + 1'b1;
               r = entry_word(astol_pkg::ST_DONE, idx);
            end
         end
         astol_pkg::OP_REMOVE: begin
            if (tbl_valid[idx]) begin
               r    = entry_word(astol_pkg::ST_DONE, idx);
               gone = tbl_order[idx];
               foreach (tbl_valid[i])
                  if (tbl_valid[i] && tbl_order[i] > gone) tbl_order[i] = tbl_order[i] - 1'b1;
               tbl_valid[idx] = 1'b0;
               if (tbl_count > 0) tbl_count = tbl_count - 1'b1;
            end
         end
         astol_pkg::OP_LOOKUP: begin
            for (int i = 0; i < CELLS; i++) begin
               if (tbl_valid[i] && tbl_order[i] == w.order_index) begin
                  r = entry_word(astol_pkg::ST_DONE, i);
                  break;
               end
            end
         end
         astol_pkg::OP_REVERSE: begin
            foreach (tbl_valid[i])
               if (tbl_valid[i] && 9'(tbl_order[i]) < tbl_count)
                  tbl_order[i] = 8'(tbl_count - 9'd1 - 9'(tbl_order[i]));
            r = entry_word(astol_pkg::ST_DONE, -1);
         end
         default: ;
      endcase
      r.count = tbl_count;
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("error: result %0d field %s is %0d, expected %0d",
               words_checked, field, got, want);
      error_count++;
   endtask

   // Request driver: presents queued words with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_results.push_back(apply_table_op(cur_op));
            op_seen[cur_op.opcode]++;
            words_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap     <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               cur_op              = pending_ops.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.opcode      <= cur_op.opcode;
               req_ch.cell_x      <= cur_op.cell_x;
               req_ch.cell_y      <= cur_op.cell_y;
               req_ch.parent_x    <= cur_op.parent_x;
               req_ch.parent_y    <= cur_op.parent_y;
               req_ch.parent_g    <= cur_op.parent_g;
               req_ch.order_index <= cur_op.order_index;
               send_gap           <= pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure and field-by-field compare.
   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_len    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               $display("error: result word with nothing outstanding");
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               status_seen[rsp_ch.status]++;
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", int'(rsp_ch.status), int'(want.status));
               if (rsp_ch.out_x !== want.out_x)
                  report_mismatch("out_x", int'(rsp_ch.out_x), int'(want.out_x));
               if (rsp_ch.out_y !== want.out_y)
                  report_mismatch("out_y", int'(rsp_ch.out_y), int'(want.out_y));
               if (rsp_ch.out_g !== want.out_g)
                  report_mismatch("out_g", int'(rsp_ch.out_g), int'(want.out_g));
               if (rsp_ch.out_h !== want.out_h)
                  report_mismatch("out_h", int'(rsp_ch.out_h), int'(want.out_h));
               if (rsp_ch.out_f !== want.out_f)
                  report_mismatch("out_f", int'(rsp_ch.out_f), int'(want.out_f));
               if (rsp_ch.out_order !== want.out_order)
                  report_mismatch("out_order", int'(rsp_ch.out_order), int'(want.out_order));
               if (rsp_ch.out_parent_x !== want.out_parent_x)
                  report_mismatch("out_parent_x", int'(rsp_ch.out_parent_x),
                                  int'(want.out_parent_x));
               if (rsp_ch.out_parent_y !== want.out_parent_y)
                  report_mismatch("out_parent_y", int'(rsp_ch.out_parent_y),
                                  int'(want.out_parent_y));
               if (rsp_ch.count !== want.count)
                  report_mismatch("count", int'(rsp_ch.count), int'(want.count));
            end
            words_checked++;
         end
         if (stall_len > 0) begin
            stall_len    <= stall_len - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_len    <= pick_gap();
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic queue_op(logic [astol_pkg::OP_W-1:0] op, int cx, int cy, int px, int py,
                           int pg, int oi);
      op_word_type w;
      w.opcode      = op;
      w.cell_x      = 4'(cx);
      w.cell_y      = 4'(cy);
      w.parent_x    = 4'(px);
      w.parent_y    = 4'(py);
      w.parent_g    = 10'(pg);
      w.order_index = 8'(oi);
      pending_ops.push_back(w);
   endtask

   // Write both goal registers back to back; valid stays high between them.
   task automatic write_goal(logic [astol_pkg::COORD_W-1:0] gx,
                             logic [astol_pkg::COORD_W-1:0] gy);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= astol_pkg::REG_GOAL_X;
      csr_ch.data  <= gx;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      goal_col = gx;
      csr_ch.index <= astol_pkg::REG_GOAL_Y;
      csr_ch.data  <= gy;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      goal_row = gy;
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_ops.size() > 0 || req_ch.valid || awaited_results.size() > 0);
   endtask

   // Random phase: mostly inserts, removes and lookups, some noise.
   task automatic queue_random_ops(int n);
      int r;
      int pg;
      for (int k = 0; k < n; k++) begin
         r  = $urandom_range(0, 99);
         pg = ($urandom_range(0, 9) == 0) ? $urandom_range(1020, 1023) : $urandom_range(0, 1023);
         if (r < 42)
            queue_op(astol_pkg::OP_INSERT, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15), pg, $urandom_range(0, 255));
         else if (r < 66)
            queue_op(astol_pkg::OP_REMOVE, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15), pg, $urandom_range(0, 255));
         else if (r < 88)
            queue_op(astol_pkg::OP_LOOKUP, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15), pg,
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 40));
         else if (r < 94)
            queue_op(astol_pkg::OP_REVERSE, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15), pg, $urandom_range(0, 255));
         else if (r < 96)
            queue_op(astol_pkg::OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15), pg, $urandom_range(0, 255));
         else
            queue_op(3'($urandom_range(5, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, 15), pg, $urandom_range(0, 255));
      end
   endtask

   // Main sequence: reset, directed words, then random phases with new goals.
   initial begin
      logic [astol_pkg::COORD_W-1:0] goal_list_x [5];
      logic [astol_pkg::COORD_W-1:0] goal_list_y [5];
      error_count   = 0;
      words_sent    = 0;
      words_checked = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (tbl_valid[i]) begin
         tbl_valid[i] = 1'b0;
         tbl_order[i] = '0;
         tbl_g[i]     = '0;
         tbl_h[i]     = '0;
         tbl_f[i]     = '0;
         tbl_px[i]    = '0;
         tbl_py[i]    = '0;
      end
      tbl_count = '0;
      goal_col  = '0;
      goal_row  = '0;
      reset     = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_goal(4'd3, 4'd9);
      // Directed: cost saturation, occupied insert, lookup miss, reverse, removes.
      queue_op(astol_pkg::OP_INSERT, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_INSERT, 15, 15, 15, 15, 1023, 255);
      queue_op(astol_pkg::OP_INSERT, 15, 0, 7, 8, 1022, 0);
      queue_op(astol_pkg::OP_INSERT, 0, 15, 3, 12, 512, 0);
      queue_op(astol_pkg::OP_INSERT, 0, 0, 5, 5, 10, 0);
      queue_op(astol_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 3);
      queue_op(astol_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 4);
      queue_op(astol_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 255);
      queue_op(astol_pkg::OP_REVERSE, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_REMOVE, 15, 15, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_REMOVE, 15, 15, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 1);
      queue_op(3'd5, 15, 15, 15, 15, 1023, 255);
      queue_op(3'd7, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_LOOKUP, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_REVERSE, 0, 0, 0, 0, 0, 0);
      queue_op(astol_pkg::OP_INSERT, 7, 9, 15, 15, 1023, 0);
      wait_idle();

      goal_list_x = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd0};
      goal_list_y = '{4'd15, 4'd15, 4'd0, 4'd0, 4'd0};
      goal_list_x[4] = 4'($urandom_range(0, 15));
      goal_list_y[4] = 4'($urandom_range(0, 15));
      for (int p = 0; p < 6; p++) begin
         if (p < 5) write_goal(goal_list_x[p], goal_list_y[p]);
         else write_goal(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         queue_random_ops(RAND_PHASE_ITEMS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() > 0) begin
         $display("error: %0d results never arrived", awaited_results.size());
         error_count++;
      end
      $display("Covered %0d words: clear %0d, insert %0d, remove %0d, lookup %0d, reverse %0d.",
               words_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
      $display("Statuses seen: done %0d, not found %0d, rejected %0d; seven goal settings.",
               status_seen[0], status_seen[1], status_seen[2]);
      if (error_count == 0)
         $display("astar_open_list_table: match");
      else
         $display("astar_open_list_table: mismatch");
      $finish;
   end

   // Watchdog.
   initial begin
      #60_000_000;
      $display("error: run timed out");
      $display("astar_open_list_table: mismatch");
      $finish;
   end

endmodule
